// ===== rtl/sab_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sab_pkg
// Shared widths, command codes and probe result type for the sorted array
// binary search core.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int POS_W   = 8;   // store position field
    localparam int DATA_W  = 32;  // entry and key width
    localparam int NUSED_W = 9;   // n_used register width
    localparam int PCNT_W  = 4;   // probe count field

    localparam logic [PCNT_W-1:0] PCNT_MAX = {PCNT_W{1'b1}};

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    // Outcome of one probe compare
    typedef struct packed {
        logic hit;    // entry equals key
        logic below;  // entry less than key (signed)
        logic empty;  // range is empty after the bound update
    } t_probe;

endpackage : sab_pkg
`default_nettype wire

// ===== rtl/sab_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sab_req_if
// Request channel: write an entry or search for a key.
// ----------------------------------------------------------------------------
interface sab_req_if;

    logic                           valid;
    logic                           ready;
    sab_pkg::t_cmd                  cmd;
    logic [sab_pkg::POS_W-1:0]      position;
    logic signed [sab_pkg::DATA_W-1:0] entry_value;
    logic signed [sab_pkg::DATA_W-1:0] search_key;

    modport source (
        output valid, cmd, position, entry_value, search_key,
        input  ready
    );

    modport sink (
        input  valid, cmd, position, entry_value, search_key,
        output ready
    );

endinterface : sab_req_if
`default_nettype wire

// ===== rtl/sab_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sab_rsp_if
// Response channel: search outcome.
// ----------------------------------------------------------------------------
interface sab_rsp_if;

    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [sab_pkg::POS_W-1:0]   found_position;
    logic [sab_pkg::PCNT_W-1:0]  probe_count;

    modport source (
        output valid, found, found_position, probe_count,
        input  ready
    );

    modport sink (
        input  valid, found, found_position, probe_count,
        output ready
    );

endinterface : sab_rsp_if
`default_nettype wire

// ===== rtl/sab_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sab_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : sab_ram
`default_nettype wire

// ===== rtl/sab_probe_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sab_probe_unit
// Shared probe datapath: midpoint of the live range, signed compare of the
// probed entry with the key and the next range bounds.
// The range is held as [lo, hi_ex) with hi_ex one past the last position.
// ----------------------------------------------------------------------------
module sab_probe_unit #(
    parameter int CW = 9
) (
    input  wire logic [CW-1:0]                      i_lo,
    input  wire logic [CW-1:0]                      i_hi_ex,
    input  wire logic signed [sab_pkg::DATA_W-1:0]  i_entry,
    input  wire logic signed [sab_pkg::DATA_W-1:0]  i_key,
    input  wire logic [CW-1:0]                      i_mid_q,
    output logic [CW-1:0]                           o_mid,
    output logic [CW-1:0]                           o_n_lo,
    output logic [CW-1:0]                           o_n_hi_ex,
    output sab_pkg::t_probe                         o_probe
);

    logic [CW:0] sum;

    // floor((lo + hi) / 2) with hi = hi_ex - 1; hi_ex >= 1 while probing
    always_comb begin
        sum   = {1'b0, i_lo} + {1'b0, i_hi_ex} - {{CW{1'b0}}, 1'b1};
        o_mid = sum[CW:1];
    end

    always_comb begin
        o_probe.hit   = (i_entry == i_key);
        o_probe.below = (i_entry < i_key);
        o_n_lo        = i_lo;
        o_n_hi_ex     = i_hi_ex;
        if (o_probe.below) begin
            o_n_lo = i_mid_q + {{(CW-1){1'b0}}, 1'b1};
        end else begin
            o_n_hi_ex = i_mid_q;
        end
        o_probe.empty = (o_n_lo >= o_n_hi_ex);
    end

endmodule : sab_probe_unit
`default_nettype wire

// ===== rtl/sorted_array_binary_search_core.sv =====
`default_nettype none
// Write request: accepted while the sequencer is idle; the sequencer stays idle, so ready stays high.
// Search request: P probes, P at most $clog2(DEPTH)+1 (9 for 256 entries). Each
// probe passes through ISSUE, which presents the midpoint to the RAM's registered
// read, and COMPARE, which checks the entry against the key in the compare unit.
// One request at a time; no request is taken while a search runs.
// Reset (synchronous, active low) idles the sequencer, drops the response
// and clears n_used; the entry store is not cleared.
// ----------------------------------------------------------------------------
// sorted_array_binary_search_core
// Entry store with a binary search sequencer over its first n_used entries.
// ----------------------------------------------------------------------------
module sorted_array_binary_search_core #(
    parameter int DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sab_pkg::NUSED_W-1:0]   i_cfg_wdata,
    sab_req_if.sink                            i_req,
    sab_rsp_if.source                          o_rsp
);

    localparam int AW = $clog2(DEPTH);      // store address width
    localparam int CW = $clog2(DEPTH + 1);  // range bound width, holds DEPTH

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_COMPARE,
        ST_DONE
    } t_state;

    t_state                                r_state;
    logic [sab_pkg::NUSED_W-1:0]           r_nused;
    logic signed [sab_pkg::DATA_W-1:0]     r_key;
    logic [CW-1:0]                         r_lo;
    logic [CW-1:0]                         r_hi_ex;
    logic [CW-1:0]                         r_mid;
    logic [sab_pkg::PCNT_W-1:0]            r_probes;
    logic                                  r_hit;
    logic                                  r_out_valid;
    logic                                  r_out_found;
    logic [sab_pkg::POS_W-1:0]             r_out_pos;
    logic [sab_pkg::PCNT_W-1:0]            r_out_pcnt;

    logic                                  req_fire;
    logic                                  wr_en;
    logic [CW-1:0]                         count;
    logic [CW-1:0]                         mid;
    logic [CW-1:0]                         n_lo;
    logic [CW-1:0]                         n_hi_ex;
    logic [sab_pkg::DATA_W-1:0]            rd_data;
    sab_pkg::t_probe                       probe;
    logic                                  out_free;

    // ------------------------------------------------------------------
    // Request side: accept only while the sequencer is idle
    // ------------------------------------------------------------------
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // Drop writes to positions past the store
    assign wr_en = req_fire && (i_req.cmd == sab_pkg::CMD_WRITE)
                 && (32'(i_req.position) < 32'(DEPTH));

    // Search range length: n_used clamped to the store depth
    always_comb begin
        if (32'(r_nused) < 32'(DEPTH)) begin
            count = CW'(r_nused);
        end else begin
            count = CW'(DEPTH);
        end
    end

    // Output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_rsp.ready;

    // ------------------------------------------------------------------
    // Entry store and shared probe unit
    // ------------------------------------------------------------------
    sab_ram #(
        .WIDTH (sab_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_req.position)),
        .i_wdata (i_req.entry_value),
        .i_raddr (mid[AW-1:0]),
        .o_rdata (rd_data)
    );

    sab_probe_unit #(
        .CW (CW)
    ) u_probe (
        .i_lo      (r_lo),
        .i_hi_ex   (r_hi_ex),
        .i_entry   ($signed(rd_data)),
        .i_key     (r_key),
        .i_mid_q   (r_mid),
        .o_mid     (mid),
        .o_n_lo    (n_lo),
        .o_n_hi_ex (n_hi_ex),
        .o_probe   (probe)
    );

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nused <= '0;
        end else if (i_cfg_we) begin
            r_nused <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Search sequencer and response register
    // ISSUE presents the midpoint to the RAM, COMPARE sees the entry and
    // narrows the range, DONE waits for the response register to free up.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drain the response once taken; DONE reloads it itself
            if (r_out_valid && o_rsp.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (req_fire && (i_req.cmd == sab_pkg::CMD_SEARCH)) begin
                        r_key    <= i_req.search_key;
                        r_lo     <= '0;
                        r_hi_ex  <= count;
                        r_probes <= '0;
                        r_hit    <= 1'b0;
                        // empty range: no probe at all
                        r_state  <= (count == '0) ? ST_DONE : ST_ISSUE;
                    end
                end

                ST_ISSUE: begin
                    r_mid   <= mid;
                    r_state <= ST_COMPARE;
                end

                ST_COMPARE: begin
                    if (r_probes != sab_pkg::PCNT_MAX) begin
                        r_probes <= r_probes + 1'b1;
                    end
                    if (probe.hit) begin
                        r_hit   <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_lo    <= n_lo;
                        r_hi_ex <= n_hi_ex;
                        r_state <= probe.empty ? ST_DONE : ST_ISSUE;
                    end
                end

                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_hit;
                        r_out_pos   <= r_hit ? sab_pkg::POS_W'(r_mid) : '0;
                        r_out_pcnt  <= r_probes;
                        r_state     <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.found          = r_out_found;
    assign o_rsp.found_position = r_out_pos;
    assign o_rsp.probe_count    = r_out_pcnt;

endmodule : sorted_array_binary_search_core
`default_nettype wire

// ===== rtl/sab_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sab_checker
// Port level checks on the search core's response channel.
// ----------------------------------------------------------------------------
module sab_checker #(
    parameter int DEPTH = 256
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_rsp_valid,
    input wire logic                         i_rsp_ready,
    input wire logic                         i_rsp_found,
    input wire logic [sab_pkg::POS_W-1:0]    i_rsp_found_position,
    input wire logic [sab_pkg::PCNT_W-1:0]   i_rsp_probe_count
);

    localparam int MAX_PROBES = ($clog2(DEPTH) + 1 > 15) ? 15 : $clog2(DEPTH) + 1;

    // Reset drops any pending response
    a_reset_drops: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid
            && $stable(i_rsp_found) && $stable(i_rsp_found_position)
            && $stable(i_rsp_probe_count))
        else $error("stalled response changed");

    // A miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_found |-> i_rsp_found_position == '0)
        else $error("miss with non-zero position");

    // A hit takes at least one probe, and no search exceeds the tree depth
    a_probe_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (32'(i_rsp_probe_count) <= MAX_PROBES)
            && (!i_rsp_found || i_rsp_probe_count != '0))
        else $error("probe count out of range");

endmodule : sab_checker

bind sorted_array_binary_search_core sab_checker #(
    .DEPTH (DEPTH)
) u_sab_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_found          (o_rsp.found),
    .i_rsp_found_position (o_rsp.found_position),
    .i_rsp_probe_count    (o_rsp.probe_count)
);
`default_nettype wire
